// ----- src/eagc_pkg.sv -----
`timescale 1ns / 1ps

package eagc_pkg;

  localparam logic [19:0] MAX_CHUNK  = 20'd524288;
  localparam logic [15:0] UNITY_GAIN = 16'd4096;
  localparam logic [3:0]  DIV_LAST   = 4'd15;

  localparam logic        RST_ENABLE    = 1'b0;
  localparam logic [15:0] RST_ATTACK    = 16'd1778;
  localparam logic [15:0] RST_RELEASE   = 16'd90;
  localparam logic [14:0] RST_FLOOR     = 15'd33;
  localparam logic [14:0] RST_THRESHOLD = 15'd4915;
  localparam logic [14:0] RST_TARGET    = 15'd16384;
  localparam logic [15:0] RST_MAX_GAIN  = 16'd32768;
  localparam logic [15:0] RST_MIN_CHUNK = 16'd160;

  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_ATTACK,
    REG_RELEASE,
    REG_FLOOR,
    REG_THRESHOLD,
    REG_TARGET,
    REG_MAX_GAIN,
    REG_MIN_CHUNK
  } reg_idx_e;

  typedef struct packed {
    logic        enable;
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
    logic [14:0] floor_level;
    logic [14:0] threshold_level;
    logic [14:0] target_level;
    logic [15:0] max_gain;
    logic [15:0] min_chunk;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_ENV_MUL,
    OP_ENV_UPD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_GAIN_MUL,
    OP_GAIN_UPD,
    OP_OUT_MUL,
    OP_OUT_WR,
    OP_BYP_WR
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_BYPASS,
    C_NO_DIV,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef logic [3:0] step_t;

  localparam step_t ST_LOAD     = 4'd0;
  localparam step_t ST_ENV_MUL  = 4'd1;
  localparam step_t ST_ENV_UPD  = 4'd2;
  localparam step_t ST_DIV_INIT = 4'd3;
  localparam step_t ST_DIV_STEP = 4'd4;
  localparam step_t ST_DIV_DONE = 4'd5;
  localparam step_t ST_GAIN_MUL = 4'd6;
  localparam step_t ST_GAIN_UPD = 4'd7;
  localparam step_t ST_OUT_MUL  = 4'd8;
  localparam step_t ST_OUT_WR   = 4'd9;
  localparam step_t ST_BYPASS   = 4'd10;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t jmp;
    step_t nxt;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic bypass;
    logic no_div;
    logic div_more;
    logic out_busy;
  } status_t;

  function automatic ctrl_word_t ucode(step_t pc);
    ctrl_word_t cw;
    unique case (pc)
      ST_LOAD:     cw = '{op: OP_LOAD,     cond: C_NO_INPUT, jmp: ST_LOAD,     nxt: ST_ENV_MUL};
      ST_ENV_MUL:  cw = '{op: OP_ENV_MUL,  cond: C_BYPASS,   jmp: ST_BYPASS,   nxt: ST_ENV_UPD};
      ST_ENV_UPD:  cw = '{op: OP_ENV_UPD,  cond: C_NEVER,    jmp: ST_LOAD,     nxt: ST_DIV_INIT};
      ST_DIV_INIT: cw = '{op: OP_DIV_INIT, cond: C_NO_DIV,   jmp: ST_GAIN_MUL, nxt: ST_DIV_STEP};
      ST_DIV_STEP: cw = '{op: OP_DIV_STEP, cond: C_DIV_MORE, jmp: ST_DIV_STEP, nxt: ST_DIV_DONE};
      ST_DIV_DONE: cw = '{op: OP_DIV_DONE, cond: C_NEVER,    jmp: ST_LOAD,     nxt: ST_GAIN_MUL};
      ST_GAIN_MUL: cw = '{op: OP_GAIN_MUL, cond: C_NEVER,    jmp: ST_LOAD,     nxt: ST_GAIN_UPD};
      ST_GAIN_UPD: cw = '{op: OP_GAIN_UPD, cond: C_NEVER,    jmp: ST_LOAD,     nxt: ST_OUT_MUL};
      ST_OUT_MUL:  cw = '{op: OP_OUT_MUL,  cond: C_NEVER,    jmp: ST_LOAD,     nxt: ST_OUT_WR};
      ST_OUT_WR:   cw = '{op: OP_OUT_WR,   cond: C_OUT_BUSY, jmp: ST_OUT_WR,   nxt: ST_LOAD};
      ST_BYPASS:   cw = '{op: OP_BYP_WR,   cond: C_OUT_BUSY, jmp: ST_BYPASS,   nxt: ST_LOAD};
      default:     cw = '{op: OP_LOAD,     cond: C_NEVER,    jmp: ST_LOAD,     nxt: ST_LOAD};
    endcase
    return cw;
  endfunction

endpackage

// ----- src/eagc_in_if.sv -----
`timescale 1ns / 1ps

interface eagc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic        [19:0] chunk_len;
  logic               restart;

  modport source (output valid, sample, chunk_len, restart, input ready);
  modport sink (input valid, sample, chunk_len, restart, output ready);
endinterface

// ----- src/eagc_out_if.sv -----
`timescale 1ns / 1ps

interface eagc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;
  logic        [15:0] gain_now;
  logic               clipped;
  logic               bypassed;

  modport source (output valid, out_sample, gain_now, clipped, bypassed, input ready);
  modport sink (input valid, out_sample, gain_now, clipped, bypassed, output ready);
endinterface

// ----- src/eagc_sequencer.sv -----
`timescale 1ns / 1ps

module eagc_sequencer import eagc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output op_e     op_o
);

  step_t      pc_q, pc_d;
  ctrl_word_t cw;
  logic       take;

  assign cw   = ucode(pc_q);
  assign op_o = cw.op;

  always_comb begin
    unique case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_NO_INPUT: take = !status_i.in_valid;
      C_BYPASS:   take = status_i.bypass;
      C_NO_DIV:   take = status_i.no_div;
      C_DIV_MORE: take = status_i.div_more;
      C_OUT_BUSY: take = status_i.out_busy;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = take ? cw.jmp : cw.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- src/eagc_datapath.sv -----
`timescale 1ns / 1ps

module eagc_datapath import eagc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  op_e           op_i,
  eagc_in_if.sink       in_i,
  eagc_out_if.source    out_o,
  output status_t       status_o
);

  logic signed [15:0] smp_q;
  logic        [19:0] chunk_q;
  logic        [23:0] env_q, env_d;
  logic        [15:0] gain_q, gain_d;
  logic        [39:0] prod_q, prod_d;
  logic               dir_q, dir_d;
  logic        [34:0] rem_q;
  logic        [38:0] dsh_q;
  logic        [15:0] quo_q;
  logic        [3:0]  cnt_q;
  logic        [15:0] tgt_q;

  logic               out_valid_q;
  logic signed [15:0] out_smp_q;
  logic        [15:0] out_gain_q;
  logic               out_clip_q, out_byp_q;

  logic        [15:0] mag;
  logic        [23:0] env_a;
  logic        [15:0] mul_a;
  logic        [23:0] mul_b;
  logic               win, ovf, bypass, div_ge;
  logic               in_fire, out_fire, out_busy, out_wr;
  logic        [19:0] scaled;
  logic               clip;
  logic signed [15:0] value;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign out_busy = out_valid_q && !out_o.ready;
  assign out_wr   = (op_i == OP_OUT_WR || op_i == OP_BYP_WR) && !out_busy;

  assign in_i.ready = (op_i == OP_LOAD);

  assign mag   = smp_q[15] ? 16'(~smp_q + 16'sd1) : smp_q;
  assign env_a = {mag, 8'b0};

  assign win    = (env_q > {1'b0, cfg_i.floor_level, 8'b0})
               && (env_q < {1'b0, cfg_i.threshold_level, 8'b0});
  assign ovf    = {5'b0, cfg_i.target_level, 4'b0} >= env_q;
  assign bypass = !cfg_i.enable || (chunk_q < {4'b0, cfg_i.min_chunk})
               || (chunk_q > MAX_CHUNK);
  assign div_ge = {4'b0, rem_q} >= dsh_q;

  assign status_o = '{in_valid: in_i.valid, bypass: bypass, no_div: !win || ovf,
                      div_more: cnt_q != 4'd0, out_busy: out_busy};

  always_comb begin
    dir_d = 1'b0;
    unique case (op_i)
      OP_ENV_MUL: begin
        dir_d = env_a > env_q;
        mul_a = dir_d ? cfg_i.attack_coeff : cfg_i.release_coeff;
        mul_b = dir_d ? env_a - env_q : env_q - env_a;
      end
      OP_GAIN_MUL: begin
        dir_d = tgt_q > gain_q;
        mul_a = dir_d ? cfg_i.attack_coeff : cfg_i.release_coeff;
        mul_b = {8'b0, dir_d ? tgt_q - gain_q : gain_q - tgt_q};
      end
      default: begin
        mul_a = mag;
        mul_b = {8'b0, gain_q};
      end
    endcase
    prod_d = {24'b0, mul_a} * {16'b0, mul_b};
  end

  always_comb begin
    env_d  = dir_q ? env_q + prod_q[39:16] : env_q - prod_q[39:16];
    gain_d = dir_q ? gain_q + prod_q[31:16] : gain_q - prod_q[31:16];
  end

  always_comb begin
    scaled = prod_q[31:12];
    if (smp_q[15]) begin
      clip  = scaled > 20'd32768;
      value = clip ? 16'sh8000 : 16'(~scaled[15:0] + 16'd1);
    end else begin
      clip  = scaled > 20'd32767;
      value = clip ? 16'sh7fff : scaled[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      gain_q      <= UNITY_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire && in_i.restart) begin
        env_q  <= '0;
        gain_q <= UNITY_GAIN;
      end
      if (op_i == OP_ENV_UPD) begin
        env_q <= env_d;
      end
      if (op_i == OP_GAIN_UPD) begin
        gain_q <= gain_d;
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q   <= in_i.sample;
      chunk_q <= in_i.chunk_len;
    end
    if (op_i == OP_ENV_MUL || op_i == OP_GAIN_MUL || op_i == OP_OUT_MUL) begin
      prod_q <= prod_d;
      dir_q  <= dir_d;
    end
    if (op_i == OP_DIV_INIT) begin
      rem_q <= {cfg_i.target_level, 20'b0};
      dsh_q <= {env_q, 15'b0};
      quo_q <= '0;
      cnt_q <= DIV_LAST;
      tgt_q <= win ? cfg_i.max_gain : UNITY_GAIN;
    end
    if (op_i == OP_DIV_STEP) begin
      if (div_ge) begin
        rem_q <= rem_q - dsh_q[34:0];
      end
      quo_q <= {quo_q[14:0], div_ge};
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - 4'd1;
    end
    if (op_i == OP_DIV_DONE) begin
      tgt_q <= (quo_q > cfg_i.max_gain) ? cfg_i.max_gain : quo_q;
    end
    if (out_wr) begin
      if (op_i == OP_BYP_WR) begin
        out_smp_q  <= smp_q;
        out_gain_q <= UNITY_GAIN;
        out_clip_q <= 1'b0;
        out_byp_q  <= 1'b1;
      end else begin
        out_smp_q  <= value;
        out_gain_q <= gain_q;
        out_clip_q <= clip;
        out_byp_q  <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_smp_q;
  assign out_o.gain_now   = out_gain_q;
  assign out_o.clipped    = out_clip_q;
  assign out_o.bypassed   = out_byp_q;

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= 24'h800000)
    else $error("envelope left its range");

  a_div_invariant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_DIV_STEP |-> {5'b0, rem_q} < {dsh_q, 1'b0})
    else $error("division remainder out of bounds");

  a_target_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_DIV_DONE |=> tgt_q <= cfg_i.max_gain)
    else $error("target gain above cap");

endmodule

// ----- src/envelope_agc_normalizer.sv -----
`timescale 1ns / 1ps

// Automatic gain control for signed 16-bit audio, one sample per transfer. A small
// microcoded sequencer steps a datapath with one shared multiplier and a restoring
// divider. When the envelope lies inside the gain window and the target gain does
// not saturate, the 16-step divider sets the pace; outside the window, or with a
// capped target, it is skipped. A bypassed sample goes from the envelope step to
// the output write, which waits while the output holds the last result. The next
// sample can be taken in the cycle after the result is registered, while that result
// may still wait on the output. Configuration is written through a plain write
// port; the user must do so only while the block is idle, which goes unchecked.

module envelope_agc_normalizer import eagc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  eagc_in_if.sink     in_i,
  eagc_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg_q;
  op_e     op;
  status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable: RST_ENABLE, attack_coeff: RST_ATTACK,
                 release_coeff: RST_RELEASE, floor_level: RST_FLOOR,
                 threshold_level: RST_THRESHOLD, target_level: RST_TARGET,
                 max_gain: RST_MAX_GAIN, min_chunk: RST_MIN_CHUNK};
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ENABLE:    cfg_q.enable          <= cfg_data_i[0];
        REG_ATTACK:    cfg_q.attack_coeff    <= cfg_data_i;
        REG_RELEASE:   cfg_q.release_coeff   <= cfg_data_i;
        REG_FLOOR:     cfg_q.floor_level     <= cfg_data_i[14:0];
        REG_THRESHOLD: cfg_q.threshold_level <= cfg_data_i[14:0];
        REG_TARGET:    cfg_q.target_level    <= cfg_data_i[14:0];
        REG_MAX_GAIN:  cfg_q.max_gain        <= cfg_data_i;
        REG_MIN_CHUNK: cfg_q.min_chunk       <= cfg_data_i;
        default:       cfg_q.enable          <= cfg_q.enable;
      endcase
    end
  end

  eagc_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  eagc_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .op_i     (op),
    .in_i     (in_i),
    .out_o    (out_o),
    .status_o (status)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while a sample is in progress");

endmodule

// ----- tb/sv/envelope_agc_normalizer_tb.sv -----
`timescale 1ns / 1ps

module envelope_agc_normalizer_tb;
  import eagc_pkg::*;

  localparam int unsigned IDLE_PERCENT = 6;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned PHASES       = 8;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic        [15:0] gain_now;
    logic               clipped;
    logic               bypassed;
  } gained_sample_t;

  // Mirrors the registers, the envelope and the smoothed gain, and keeps the
  // gained samples that are still owed by the block in transfer order.
  class agc_gain_tracker;
    cfg_t           regs;
    logic [23:0]    envelope;
    logic [15:0]    gain;
    gained_sample_t pending_results[$];
    int unsigned    mismatches;

    function new();
      regs = '{enable: RST_ENABLE, attack_coeff: RST_ATTACK, release_coeff: RST_RELEASE,
               floor_level: RST_FLOOR, threshold_level: RST_THRESHOLD,
               target_level: RST_TARGET, max_gain: RST_MAX_GAIN, min_chunk: RST_MIN_CHUNK};
      envelope   = '0;
      gain       = UNITY_GAIN;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [15:0] data);
      case (idx)
        REG_ENABLE:    regs.enable          = data[0];
        REG_ATTACK:    regs.attack_coeff    = data;
        REG_RELEASE:   regs.release_coeff   = data;
        REG_FLOOR:     regs.floor_level     = data[14:0];
        REG_THRESHOLD: regs.threshold_level = data[14:0];
        REG_TARGET:    regs.target_level    = data[14:0];
        REG_MAX_GAIN:  regs.max_gain        = data;
        REG_MIN_CHUNK: regs.min_chunk       = data;
        default: ;
      endcase
    endfunction

    // Moves cur toward goal by a Q0.16 fraction of the distance, truncated.
    function logic [31:0] glide(logic [31:0] cur, logic [31:0] goal,
                                logic [15:0] up, logic [15:0] down);
      logic [63:0] delta;
      if (goal > cur) begin
        delta = (64'(up) * 64'(goal - cur)) >> 16;
        return cur + delta[31:0];
      end
      delta = (64'(down) * 64'(cur - goal)) >> 16;
      return cur - delta[31:0];
    endfunction

    function void note_input(logic [15:0] raw, logic [19:0] chunk, logic restart);
      gained_sample_t res;
      logic [16:0]    mag;
      logic [31:0]    goal;
      logic [31:0]    moved;
      logic [63:0]    quot;
      logic [31:0]    prod;
      if (restart) begin
        envelope = '0;
        gain     = UNITY_GAIN;
      end
      mag = raw[15] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
      if (!regs.enable || chunk < regs.min_chunk || chunk > MAX_CHUNK) begin
        res = '{out_sample: raw, gain_now: UNITY_GAIN, clipped: 1'b0, bypassed: 1'b1};
      end else begin
        moved = glide(32'(envelope), 32'(mag) << 8, regs.attack_coeff, regs.release_coeff);
        envelope = moved[23:0];
        goal = 32'(UNITY_GAIN);
        if (envelope > {regs.floor_level, 8'd0} && envelope < {regs.threshold_level, 8'd0})
            begin
          quot = {29'd0, regs.target_level, 20'd0} / 64'(envelope);
          goal = (quot > 64'(regs.max_gain)) ? 32'(regs.max_gain) : quot[31:0];
        end
        moved = glide(32'(gain), goal, regs.attack_coeff, regs.release_coeff);
        gain = moved[15:0];
        prod = (32'(mag) * 32'(gain)) >> 12;
        res.clipped  = 1'b0;
        res.bypassed = 1'b0;
        res.gain_now = gain;
        if (raw[15]) begin
          if (prod > 32'd32768) begin
            prod = 32'd32768;
            res.clipped = 1'b1;
          end
          res.out_sample = 16'(32'd0 - prod);
        end else begin
          if (prod > 32'd32767) begin
            prod = 32'd32767;
            res.clipped = 1'b1;
          end
          res.out_sample = prod[15:0];
        end
      end
      pending_results.push_back(res);
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_result(gained_sample_t got);
      gained_sample_t want;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.out_sample !== want.out_sample) report("out_sample", want.out_sample, got.out_sample);
      if (got.gain_now !== want.gain_now) report("gain_now", want.gain_now, got.gain_now);
      if (got.clipped !== want.clipped) report("clipped", 16'(want.clipped), 16'(got.clipped));
      if (got.bypassed !== want.bypassed)
        report("bypassed", 16'(want.bypassed), 16'(got.bypassed));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;
  logic        steady = 1'b0;
  int unsigned quiet_cycles = 0;

  agc_gain_tracker tracker;
  gained_sample_t  seen;

  eagc_in_if  in_bus();
  eagc_out_if out_bus();

  envelope_agc_normalizer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(negedge clk_i) begin
    out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready)
        tracker.note_input(in_bus.sample, in_bus.chunk_len, in_bus.restart);
      if (out_bus.valid && out_bus.ready) begin
        seen.out_sample = out_bus.out_sample;
        seen.gain_now   = out_bus.gain_now;
        seen.clipped    = out_bus.clipped;
        seen.bypassed   = out_bus.bypassed;
        tracker.check_result(seen);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(int value, logic [19:0] len, logic restart);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample    <= 16'(value);
    in_bus.chunk_len <= len;
    in_bus.restart   <= restart;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_reg(reg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(cfg_t c);
    quiesce();
    program_reg(REG_ENABLE, 16'(c.enable));
    program_reg(REG_ATTACK, c.attack_coeff);
    program_reg(REG_RELEASE, c.release_coeff);
    program_reg(REG_FLOOR, 16'(c.floor_level));
    program_reg(REG_THRESHOLD, 16'(c.threshold_level));
    program_reg(REG_TARGET, 16'(c.target_level));
    program_reg(REG_MAX_GAIN, c.max_gain);
    program_reg(REG_MIN_CHUNK, c.min_chunk);
  endtask

  function automatic cfg_t phase_config(int unsigned phase);
    cfg_t c;
    c = '{enable: 1'b1, attack_coeff: RST_ATTACK, release_coeff: RST_RELEASE,
          floor_level: RST_FLOOR, threshold_level: RST_THRESHOLD, target_level: RST_TARGET,
          max_gain: RST_MAX_GAIN, min_chunk: RST_MIN_CHUNK};
    case (phase)
      0: ;
      1: c = '{enable: 1'b1, attack_coeff: 16'hFFFF, release_coeff: 16'hFFFF, floor_level: '0,
               threshold_level: 15'h7FFF, target_level: 15'h7FFF, max_gain: 16'hFFFF,
               min_chunk: '0};
      2: c = '{enable: 1'b1, attack_coeff: '0, release_coeff: '0, floor_level: 15'h7FFF,
               threshold_level: '0, target_level: '0, max_gain: UNITY_GAIN,
               min_chunk: 16'hFFFF};
      3: c.enable = 1'b0;
      4, 6: begin
        c.attack_coeff    = 16'($urandom);
        c.release_coeff   = 16'($urandom);
        c.floor_level     = 15'($urandom_range(3000));
        c.threshold_level = 15'($urandom_range(32767, c.floor_level));
        c.target_level    = 15'($urandom);
        c.max_gain        = 16'($urandom_range(65535, 4096));
        c.min_chunk       = 16'($urandom_range(400));
      end
      default: begin
        c.attack_coeff    = 16'($urandom_range(6000, 300));
        c.release_coeff   = 16'($urandom_range(600, 10));
        c.floor_level     = 15'($urandom_range(200));
        c.threshold_level = 15'($urandom_range(12000, 2000));
        c.target_level    = 15'($urandom_range(32767, 4000));
        c.max_gain        = 16'($urandom_range(65535, 4096));
        c.min_chunk       = 16'($urandom_range(300));
      end
    endcase
    return c;
  endfunction

  // Mostly bursts of one chunk length and one level of loudness, most with a
  // restart up front, mixed with stray samples whose chunk length and restart are random.
  task automatic run_phase(int unsigned count);
    int unsigned sent;
    int unsigned amp;
    int unsigned burst;
    logic [19:0] len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_sample(int'($urandom), 20'($urandom), 1'($urandom_range(1)));
        sent++;
      end else begin
        case ($urandom_range(7))
          0: len = 20'(tracker.regs.min_chunk);
          1: len = MAX_CHUNK;
          2: len = 20'($urandom_range(MAX_CHUNK, tracker.regs.min_chunk));
          default: len = 20'($urandom_range(tracker.regs.min_chunk + 1000,
                                            tracker.regs.min_chunk));
        endcase
        case ($urandom_range(3))
          0: amp = 60;
          1: amp = 2000;
          2: amp = 12000;
          default: amp = 32767;
        endcase
        burst = $urandom_range(40, 4);
        for (int unsigned k = 0; k < burst; k++) begin
          send_sample(int'($urandom_range(2 * amp)) - int'(amp), len,
                      k == 0 && $urandom_range(3) != 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    in_bus.valid     = 1'b0;
    in_bus.sample    = '0;
    in_bus.chunk_len = '0;
    in_bus.restart   = 1'b0;
    out_bus.ready    = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_ENABLE;
    cfg_data         = '0;
    rst_ni           = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Disabled after reset, so everything passes through.
    send_sample(32767, 20'd200, 1'b0);
    send_sample(-32768, 20'd200, 1'b1);

    // Instant attack: the gain jumps to the cap and then clips loud samples.
    apply_config('{enable: 1'b1, attack_coeff: 16'hFFFF, release_coeff: RST_RELEASE,
                   floor_level: RST_FLOOR, threshold_level: RST_THRESHOLD,
                   target_level: RST_TARGET, max_gain: RST_MAX_GAIN,
                   min_chunk: RST_MIN_CHUNK});
    send_sample(-32768, 20'd160, 1'b1);
    send_sample(32767, MAX_CHUNK, 1'b0);
    send_sample(0, 20'd159, 1'b0);
    send_sample(1, MAX_CHUNK + 20'd1, 1'b0);
    send_sample(-1, 20'hFFFFF, 1'b0);
    send_sample(0, 20'd0, 1'b1);
    send_sample(1000, 20'd1000, 1'b1);
    send_sample(1000, 20'd1000, 1'b0);
    send_sample(32767, 20'd1000, 1'b0);
    send_sample(-32768, 20'd1000, 1'b0);

    // Floor equal to threshold leaves no window, so the target stays at unity.
    apply_config('{enable: 1'b1, attack_coeff: 16'hFFFF, release_coeff: '0,
                   floor_level: 15'd100, threshold_level: 15'd100,
                   target_level: RST_TARGET, max_gain: RST_MAX_GAIN, min_chunk: '0});
    send_sample(5000, 20'd10, 1'b1);
    send_sample(-20, 20'd10, 1'b0);

    // A cap below unity pulls the gain down.
    apply_config('{enable: 1'b1, attack_coeff: 16'hFFFF, release_coeff: 16'hFFFF,
                   floor_level: '0, threshold_level: 15'h7FFF, target_level: 15'h7FFF,
                   max_gain: 16'd2048, min_chunk: '0});
    send_sample(1000, 20'd10, 1'b1);
    send_sample(-30000, 20'd10, 1'b0);
    send_sample(7, 20'd10, 1'b0);

    // Zero attack holds the envelope and the gain on the way up.
    apply_config('{enable: 1'b1, attack_coeff: '0, release_coeff: 16'd4000,
                   floor_level: RST_FLOOR, threshold_level: RST_THRESHOLD,
                   target_level: RST_TARGET, max_gain: RST_MAX_GAIN, min_chunk: '0});
    send_sample(2000, 20'd10, 1'b1);
    send_sample(-2000, 20'd10, 1'b0);
    send_sample(32767, 20'd10, 1'b0);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      apply_config(phase_config(phase));
      steady = (phase == 5);
      run_phase(PHASE_ITEMS);
    end
    steady = 1'b0;

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/eagc_pkg.sv
src/eagc_in_if.sv
src/eagc_out_if.sv
src/eagc_sequencer.sv
src/eagc_datapath.sv
src/envelope_agc_normalizer.sv
tb/sv/envelope_agc_normalizer_tb.sv
